/* sv/pls_pkg.sv */
package pls_pkg;

	localparam int KIND_W      = 2;
	localparam int POS_W       = 4;
	localparam int ITEM_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic exec;
	} pls_cmd_t;

endpackage

/* sv/pls_req_if.sv */
interface pls_req_if
	import pls_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [ITEM_W-1:0] item_data;

	modport source (output valid, output kind, output position, output item_data, input ready);
	modport sink (input valid, input kind, input position, input item_data, output ready);
endinterface

/* sv/pls_rsp_if.sv */
interface pls_rsp_if
	import pls_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [ITEM_W-1:0]      result_data;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output status, output result_data, output entry_count,
		input ready);
	modport sink (input valid, input status, input result_data, input entry_count,
		output ready);
endinterface

/* sv/pls_ctrl.sv */
module pls_ctrl
	import pls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pls_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign cmd.exec  = accept;
	assign out_valid = (state_q == ST_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_ready && !accept) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/pls_datapath.sv */
module pls_datapath
	import pls_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pls_cmd_t               cmd,
	input  logic [KIND_W-1:0]      kind,
	input  logic [POS_W-1:0]       position,
	input  logic [ITEM_W-1:0]      item_data,
	output logic [STATUS_W-1:0]    status,
	output logic [ITEM_W-1:0]      result_data,
	output logic [COUNT_OUT_W-1:0] entry_count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];
	logic [CW-1:0]         count_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ITEM_W-1:0]     result_q;
	logic [COUNT_OUT_W-1:0] ecount_q;

	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [IW-1:0]         pidx;
	logic                  pos_ok;
	logic                  full;
	logic                  do_ins;
	logic                  do_rem;
	logic [STATUS_W-1:0]   status_d;
	logic [ITEM_W-1:0]     result_d;
	logic [CW-1:0]         count_d;

	assign word    = DATA_WIDTH'(item_data);
	assign pidx    = IW'(position);
	assign rd_word = entries_q[pidx];
	assign pos_ok  = CMPW'(position) < CMPW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = STATUS_RANGE;
		result_d = '0;
		count_d  = count_q;
		case (kind)
			KIND_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					status_d = STATUS_DONE;
					do_ins   = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (pos_ok) begin
					status_d = STATUS_DONE;
					result_d = ITEM_W'(rd_word);
					do_rem   = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
			KIND_READ: begin
				if (pos_ok) begin
					status_d = STATUS_DONE;
					result_d = ITEM_W'(rd_word);
				end
			end
			default: begin
				status_d = STATUS_RANGE;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
		logic [DATA_WIDTH-1:0] ins_src;
		logic [DATA_WIDTH-1:0] rem_src;
		logic                  rem_hit;

		if (g == 0) begin : g_head
			assign ins_src = word;
		end else begin : g_body
			assign ins_src = entries_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign rem_src = entries_q[g];
			assign rem_hit = 1'b0;
		end else begin : g_mid
			assign rem_src = entries_q[g+1];
			assign rem_hit = (IW'(g) >= pidx);
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && do_ins) begin
				entries_q[g] <= ins_src;
			end else if (cmd.exec && do_rem && rem_hit) begin
				entries_q[g] <= rem_src;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			result_q <= result_d;
			ecount_q <= COUNT_OUT_W'(count_d);
		end
	end

	assign status      = status_q;
	assign result_data = result_q;
	assign entry_count = ecount_q;

endmodule

/* sv/positional_list_store.sv */
// Bounded ordered list of payload words, up to CAPACITY entries.
// Request channel (req): kind selects insert at front, remove at position or
// read at position; position and item_data travel with every transfer.
// Response channel (rsp): one transfer per request carrying status (done,
// position out of range, list full), result_data (removed or read word, zero
// otherwise) and entry_count after the request.
// The response is valid the cycle after the request transfer.
// Throughput: one request per cycle while responses are taken; all entries
// shift in parallel through a register array in the datapath on insert and remove.
// The output register holds one response; req.ready stays high while that
// register is empty or being drained in the same cycle.
// When the receiver stalls, the response holds and req.ready drops until the
// response transfer completes.
// Reset clears the entry count and drops any pending response; stored words
// are not cleared and are never returned before being written.
module positional_list_store
	import pls_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	pls_req_if.sink    req,
	pls_rsp_if.source  rsp
);

	pls_cmd_t cmd;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	pls_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (req.kind),
		.position    (req.position),
		.item_data   (req.item_data),
		.status      (rsp.status),
		.result_data (rsp.result_data),
		.entry_count (rsp.entry_count)
	);

endmodule

/* verif/positional_list_store_tb.sv */
module positional_list_store_tb;
	import pls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASE_LEN    = 40;
	localparam int LONG_HOLD    = 60;
	localparam int HOLD_AT_A    = 300;
	localparam int HOLD_AT_B    = 900;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  position;
		logic [ITEM_W-1:0] item_data;
		bit                drain_first;
	} list_req_t;

	typedef struct {
		logic [STATUS_W-1:0]    status;
		logic [ITEM_W-1:0]      result_data;
		logic [COUNT_OUT_W-1:0] entry_count;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	pls_req_if req_bus ();
	pls_rsp_if rsp_bus ();

	positional_list_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	list_req_t pending_reqs[$];
	list_rsp_t expected_rsps[$];

	logic [ITEM_W-1:0] words_held [DEF_CAPACITY];
	int held_count;
	int gen_held;
	int accepted;
	int errors;
	int cycles;
	bit req_taken;
	int send_gap;
	int recv_gap;
	int hold_left;
	int hold_idx;

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((accepted / 150) % 4 == 3)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic list_rsp_t apply_request(list_req_t r);
		list_rsp_t o;
		int i;
		o.status = STATUS_RANGE;
		o.result_data = '0;
		case (r.kind)
			KIND_INSERT: begin
				if (held_count >= DEF_CAPACITY) begin
					o.status = STATUS_FULL;
				end else begin
					for (i = held_count; i > 0; i--)
						words_held[i] = words_held[i-1];
					words_held[0] = r.item_data;
					held_count++;
					o.status = STATUS_DONE;
				end
			end
			KIND_REMOVE: begin
				if (r.position < held_count) begin
					o.result_data = words_held[r.position];
					for (i = r.position; i + 1 < held_count; i++)
						words_held[i] = words_held[i+1];
					held_count--;
					o.status = STATUS_DONE;
				end
			end
			KIND_READ: begin
				if (r.position < held_count) begin
					o.result_data = words_held[r.position];
					o.status = STATUS_DONE;
				end
			end
			default: begin
			end
		endcase
		o.entry_count = held_count[COUNT_OUT_W-1:0];
		return o;
	endfunction

	task automatic add_item(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
			logic [ITEM_W-1:0] item_data, bit drain_first);
		list_req_t r;
		r.kind = kind;
		r.position = position;
		r.item_data = item_data;
		r.drain_first = drain_first;
		pending_reqs.push_back(r);
		if (kind == KIND_INSERT && gen_held < DEF_CAPACITY)
			gen_held++;
		else if (kind == KIND_REMOVE && position < gen_held)
			gen_held--;
	endtask

	task automatic build_stimulus();
		int n;
		int ins_pct;
		int r;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0] position;
		logic [ITEM_W-1:0] data;
		add_item(KIND_READ, 4'd0, 32'h0, 1'b0);
		add_item(KIND_REMOVE, 4'd15, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_UNUSED, 4'd0, 32'h1234_5678, 1'b0);
		add_item(KIND_INSERT, 4'd15, 32'h0000_0000, 1'b0);
		add_item(KIND_INSERT, 4'd0, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_READ, 4'd1, 32'h0, 1'b0);
		add_item(KIND_READ, 4'd2, 32'h0, 1'b0);
		add_item(KIND_REMOVE, 4'd0, 32'h0, 1'b0);
		add_item(KIND_REMOVE, 4'd0, 32'h0, 1'b0);
		for (n = 0; n < DEF_CAPACITY; n++)
			add_item(KIND_INSERT, 4'($urandom), $urandom, 1'b0);
		add_item(KIND_INSERT, 4'd0, 32'hA5A5_5A5A, 1'b0);
		add_item(KIND_READ, 4'd15, 32'h0, 1'b0);
		add_item(KIND_REMOVE, 4'd15, 32'h0, 1'b0);
		ins_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				r = $urandom_range(0, 2);
				ins_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
			end
			r = $urandom_range(0, 99);
			if (r < 2)
				kind = KIND_UNUSED;
			else if ($urandom_range(0, 99) < ins_pct)
				kind = KIND_INSERT;
			else if ($urandom_range(0, 1) == 0)
				kind = KIND_REMOVE;
			else
				kind = KIND_READ;
			if (gen_held > 0 && $urandom_range(0, 9) < 8)
				position = POS_W'($urandom_range(0, gen_held - 1));
			else
				position = POS_W'($urandom_range(0, 15));
			r = $urandom_range(0, 9);
			data = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
			add_item(kind, position, data, (n % 350 == 0));
		end
	endtask

	always @(negedge clk) begin : request_driver
		list_req_t nxt;
		if (arst_n) begin
			if (!req_bus.valid || req_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].drain_first && expected_rsps.size() != 0)) begin
					nxt = pending_reqs.pop_front();
					req_bus.valid     <= 1'b1;
					req_bus.kind      <= nxt.kind;
					req_bus.position  <= nxt.position;
					req_bus.item_data <= nxt.item_data;
					send_gap = pick_gap();
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : response_stall
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if ((hold_idx == 0 && accepted >= HOLD_AT_A) ||
					(hold_idx == 1 && accepted >= HOLD_AT_B)) begin
				hold_idx++;
				hold_left = LONG_HOLD - 1;
				rsp_bus.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : list_scoreboard
		list_rsp_t want;
		list_req_t took;
		req_taken <= arst_n && req_bus.valid && req_bus.ready;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response transfer with no request outstanding");
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						errors++;
					end
					if (rsp_bus.result_data !== want.result_data) begin
						$error("result_data: expected %08h, got %08h",
							want.result_data, rsp_bus.result_data);
						errors++;
					end
					if (rsp_bus.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp_bus.entry_count);
						errors++;
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				took.kind = req_bus.kind;
				took.position = req_bus.position;
				took.item_data = req_bus.item_data;
				took.drain_first = 1'b0;
				expected_rsps.push_back(apply_request(took));
				accepted++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.kind = KIND_INSERT;
		req_bus.position = '0;
		req_bus.item_data = '0;
		rsp_bus.ready = 1'b0;
		held_count = 0;
		gen_held = 0;
		accepted = 0;
		errors = 0;
		cycles = 0;
		req_taken = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		hold_left = 0;
		hold_idx = 0;
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
